// ----- hw/rtl/rgbab_pkg.sv -----
package rgbab_pkg;

    localparam int unsigned DimW  = 12;
    localparam int unsigned CoordW = 13;
    localparam int unsigned ChanW = 8;
    localparam int unsigned PixW  = 16;
    localparam int unsigned ProdW = 2 * ChanW;

    localparam logic [DimW-1:0]  FrameWidthRst    = 12'd320;
    localparam logic [DimW-1:0]  FrameHeightRst   = 12'd240;
    localparam logic [ChanW-1:0] AlphaVisibleMin  = 8'd8;
    localparam logic [ChanW-1:0] AlphaOpaqueMin   = 8'd250;
    localparam logic [ChanW-1:0] ChanMax          = 8'd255;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    // Stage 1 payload: clip result and channel products
    typedef struct packed {
        logic             we;
        logic             opaque;
        logic [PixW-1:0]  dest;
        logic [ChanW-1:0] src_r;
        logic [ChanW-1:0] src_g;
        logic [ChanW-1:0] src_b;
        logic [ProdW-1:0] ps_r;
        logic [ProdW-1:0] ps_g;
        logic [ProdW-1:0] ps_b;
        logic [ProdW-1:0] pd_r;
        logic [ProdW-1:0] pd_g;
        logic [ProdW-1:0] pd_b;
    } t_s1;

    // Stage 2 payload: blended channels
    typedef struct packed {
        logic             we;
        logic             opaque;
        logic [PixW-1:0]  dest;
        logic [ChanW-1:0] src_r;
        logic [ChanW-1:0] src_g;
        logic [ChanW-1:0] src_b;
        logic [ChanW-1:0] mix_r;
        logic [ChanW-1:0] mix_g;
        logic [ChanW-1:0] mix_b;
    } t_s2;

    function automatic logic [PixW-1:0] pack565(
        input logic [ChanW-1:0] r,
        input logic [ChanW-1:0] g,
        input logic [ChanW-1:0] b
    );
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

// ----- hw/rtl/rgb565_alpha_blend_clip_top.sv -----
// RGB565 source-over alpha blend with frame clipping. Each request carries one
// RGBA8888 source pixel, its signed destination coordinates and the current
// RGB565 destination pixel; each result gives a write flag and the pixel to
// write. Pixels off the frame (frame_width, frame_height set over APB at
// 0x0 and 0x4) or with alpha below 8 are not written and return dest_pixel
// unchanged; alpha of 250 or more packs the source directly; otherwise each
// channel is (src*a + dst*(255-a))/255, truncated. The block takes one
// request per clock while the result side is not stalled; products, divide
// by 255, pack and select each sit behind a register stage. Every stage
// advances on its own when its successor has room, so a stall on the
// result side holds the pipeline without losing or repeating data.
module rgb565_alpha_blend_clip_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rgbab_pkg::CoordW-1:0]  i_dest_x,
    input  logic [rgbab_pkg::CoordW-1:0]  i_dest_y,
    input  logic [rgbab_pkg::ChanW-1:0]   i_src_red,
    input  logic [rgbab_pkg::ChanW-1:0]   i_src_green,
    input  logic [rgbab_pkg::ChanW-1:0]   i_src_blue,
    input  logic [rgbab_pkg::ChanW-1:0]   i_src_alpha,
    input  logic [rgbab_pkg::PixW-1:0]    i_dest_pixel,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_write_enable,
    output logic [rgbab_pkg::PixW-1:0]    o_pixel_out,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [rgbab_pkg::DimW-1:0] r_frame_width;
    logic [rgbab_pkg::DimW-1:0] r_frame_height;
    rgbab_pkg::t_reg_idx        reg_idx;
    logic                       cfg_wr;

    logic           s1_valid;
    rgbab_pkg::t_s1 s1_stage;
    logic           s2_valid;
    rgbab_pkg::t_s2 s2_stage;

    logic                        r_out_valid;
    logic                        r_out_we;
    logic [rgbab_pkg::PixW-1:0]  r_out_px;
    logic [rgbab_pkg::PixW-1:0]  n_out_px;

    logic adv_out;
    logic adv2;
    logic adv1;

    // ------------------------------------------------------------------
    // Configuration: word registers at 0x0 and 0x4, no wait states
    // ------------------------------------------------------------------
    assign reg_idx = rgbab_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= rgbab_pkg::FrameWidthRst;
            r_frame_height <= rgbab_pkg::FrameHeightRst;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                rgbab_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[rgbab_pkg::DimW-1:0];
                end
                rgbab_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[rgbab_pkg::DimW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rgbab_pkg::REG_FRAME_WIDTH:  prdata = {20'd0, r_frame_width};
            rgbab_pkg::REG_FRAME_HEIGHT: prdata = {20'd0, r_frame_height};
            default:                     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage advance: a stage moves when it is empty or its successor moves
    // ------------------------------------------------------------------
    assign adv_out = !r_out_valid || i_ready;
    assign adv2    = !s2_valid || adv_out;
    assign adv1    = !s1_valid || adv2;
    assign o_ready = adv1;

    // Stage 1: clip, alpha thresholds, channel products
    rgbab_mul u_mul (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv1),
        .i_valid        (i_valid),
        .i_dest_x       (i_dest_x),
        .i_dest_y       (i_dest_y),
        .i_src_red      (i_src_red),
        .i_src_green    (i_src_green),
        .i_src_blue     (i_src_blue),
        .i_src_alpha    (i_src_alpha),
        .i_dest_pixel   (i_dest_pixel),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_valid        (s1_valid),
        .o_stage        (s1_stage)
    );

    // Stage 2: sum of products and divide by 255
    rgbab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv2),
        .i_valid (s1_valid),
        .i_stage (s1_stage),
        .o_valid (s2_valid),
        .o_stage (s2_stage)
    );

    // ------------------------------------------------------------------
    // Stage 3: repack and select the pixel to write
    // ------------------------------------------------------------------
    always_comb begin
        priority if (!s2_stage.we) begin
            n_out_px = s2_stage.dest;
        end else if (s2_stage.opaque) begin
            n_out_px = rgbab_pkg::pack565(s2_stage.src_r, s2_stage.src_g, s2_stage.src_b);
        end else begin
            n_out_px = rgbab_pkg::pack565(s2_stage.mix_r, s2_stage.mix_g, s2_stage.mix_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= s2_valid;
        end
    end

    // Hold the result while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (adv_out) begin
            r_out_we <= s2_stage.we;
            r_out_px <= n_out_px;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_write_enable = r_out_we;
    assign o_pixel_out    = r_out_px;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    // A near-transparent request never carries a write flag into stage 1
    a_alpha_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_src_alpha < rgbab_pkg::AlphaVisibleMin))
            |=> (s1_valid && !s1_stage.we))
        else $error("near-transparent request marked for write");

    // A stalled stage 1 keeps its item intact
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && !adv2) |=> (s1_valid && $stable(s1_stage)))
        else $error("stage 1 item lost or changed during stall");

    // An item leaving stage 2 lands in the output register
    a_s2_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_valid && adv_out) |=> r_out_valid)
        else $error("stage 2 item dropped");
`endif

endmodule

// ----- hw/rtl/rgbab_mul.sv -----
module rgbab_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic [rgbab_pkg::CoordW-1:0]  i_dest_x,
    input  logic [rgbab_pkg::CoordW-1:0]  i_dest_y,
    input  logic [rgbab_pkg::ChanW-1:0]   i_src_red,
    input  logic [rgbab_pkg::ChanW-1:0]   i_src_green,
    input  logic [rgbab_pkg::ChanW-1:0]   i_src_blue,
    input  logic [rgbab_pkg::ChanW-1:0]   i_src_alpha,
    input  logic [rgbab_pkg::PixW-1:0]    i_dest_pixel,
    input  logic [rgbab_pkg::DimW-1:0]    i_frame_width,
    input  logic [rgbab_pkg::DimW-1:0]    i_frame_height,
    output logic                          o_valid,
    output rgbab_pkg::t_s1                o_stage
);

    logic                        r_valid;
    rgbab_pkg::t_s1              r_stage;
    rgbab_pkg::t_s1              n_stage;
    logic                        on_frame;
    logic [rgbab_pkg::ChanW-1:0] inv_a;
    logic [rgbab_pkg::ChanW-1:0] dst_r;
    logic [rgbab_pkg::ChanW-1:0] dst_g;
    logic [rgbab_pkg::ChanW-1:0] dst_b;

    always_comb begin
        // Sign bit clear means column/row is non-negative and fits 12 bits
        on_frame = !i_dest_x[rgbab_pkg::CoordW-1] && !i_dest_y[rgbab_pkg::CoordW-1]
                && (i_dest_x[rgbab_pkg::DimW-1:0] < i_frame_width)
                && (i_dest_y[rgbab_pkg::DimW-1:0] < i_frame_height);
        inv_a  = rgbab_pkg::ChanMax - i_src_alpha;
        // Unpack by left shift, no bit replication
        dst_r  = {i_dest_pixel[15:11], 3'b000};
        dst_g  = {i_dest_pixel[10:5], 2'b00};
        dst_b  = {i_dest_pixel[4:0], 3'b000};

        n_stage.we     = on_frame && (i_src_alpha >= rgbab_pkg::AlphaVisibleMin);
        n_stage.opaque = (i_src_alpha >= rgbab_pkg::AlphaOpaqueMin);
        n_stage.dest   = i_dest_pixel;
        n_stage.src_r  = i_src_red;
        n_stage.src_g  = i_src_green;
        n_stage.src_b  = i_src_blue;
        n_stage.ps_r   = i_src_red   * i_src_alpha;
        n_stage.ps_g   = i_src_green * i_src_alpha;
        n_stage.ps_b   = i_src_blue  * i_src_alpha;
        n_stage.pd_r   = dst_r * inv_a;
        n_stage.pd_g   = dst_g * inv_a;
        n_stage.pd_b   = dst_b * inv_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ----- hw/rtl/rgbab_div.sv -----
module rgbab_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  rgbab_pkg::t_s1 i_stage,
    output logic           o_valid,
    output rgbab_pkg::t_s2 o_stage
);

    logic           r_valid;
    rgbab_pkg::t_s2 r_stage;
    rgbab_pkg::t_s2 n_stage;

    // Exact floor(x/255) for x below 65535: (x + (x>>8) + 1) >> 8
    function automatic logic [rgbab_pkg::ChanW-1:0] mix(
        input logic [rgbab_pkg::ProdW-1:0] ps,
        input logic [rgbab_pkg::ProdW-1:0] pd
    );
        logic [rgbab_pkg::ProdW:0] sum;
        logic [rgbab_pkg::ProdW:0] adj;
        sum = {1'b0, ps} + {1'b0, pd};
        adj = sum + {8'd0, sum[rgbab_pkg::ProdW:8]} + 17'd1;
        return adj[15:8];
    endfunction

    always_comb begin
        n_stage.we     = i_stage.we;
        n_stage.opaque = i_stage.opaque;
        n_stage.dest   = i_stage.dest;
        n_stage.src_r  = i_stage.src_r;
        n_stage.src_g  = i_stage.src_g;
        n_stage.src_b  = i_stage.src_b;
        n_stage.mix_r  = mix(i_stage.ps_r, i_stage.pd_r);
        n_stage.mix_g  = mix(i_stage.ps_g, i_stage.pd_g);
        n_stage.mix_b  = mix(i_stage.ps_b, i_stage.pd_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
